// File: rtl/kms_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
`default_nettype none
package kms_pkg;

  localparam logic signed [35:0] CordicX0 = 36'sd652032874;
  localparam logic signed [47:0] RadToBau = 48'sd683565276;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegCouplingGain = 2'd1;
  localparam logic [1:0] RegTimeStep = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  node_index;
    logic [31:0] natural_freq;
    logic [31:0] init_phase;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  out_node;
    logic [31:0] phase;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic signed [35:0] cos_v;
    logic signed [35:0] sin_v;
  } cordic_res_t;

  function automatic logic [31:0] atan_angle(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/kms_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`default_nettype none
module kms_cordic #(
  parameter int STAGES = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire  [31:0]          angle,
  output logic                 done,
  output kms_pkg::cordic_res_t res
);

  localparam int CntW = $clog2(STAGES);

  logic               busy;
  logic               flip;
  logic [CntW-1:0]    cnt;
  logic signed [35:0] x, y, xs, ys, x_next, y_next;
  logic signed [33:0] z, z_next, at;
  logic               a_flip;
  logic [31:0]        a_sum;

  always_comb begin
    a_sum = angle + 32'h40000000;
    a_flip = a_sum[31];
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = 34'($signed({1'b0, kms_pkg::atan_angle(5'(cnt))}));
    if (!z[33]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CntW'(STAGES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      flip <= a_flip;
      x <= kms_pkg::CordicX0;
      y <= '0;
      z <= 34'($signed(a_flip ? (angle ^ 32'h80000000) : angle));
    end else if (busy) begin
      z <= z_next;
      if (cnt == CntW'(STAGES - 1) && flip) begin
        x <= -x_next;
        y <= -y_next;
      end else begin
        x <= x_next;
        y <= y_next;
      end
    end
  end

  assign res.cos_v = x;
  assign res.sin_v = y;

endmodule
`default_nettype wire

// File: rtl/kuramoto_mean_field_step_unit.sv
// Top level: Kuramoto mean-field Euler step engine with APB configuration.
// A load word does not raise busy. A step word for n nodes keeps busy high through a mean
// pass over the nodes, the two mean divides and an update pass over the nodes.
// Results come one per node, each valid for one cycle; no stall.
// Synchronous reset clears control state and restores the register defaults.
`default_nettype none
module kuramoto_mean_field_step_unit #(
  parameter int MAX_NODES = 64,
  parameter int CORDIC_STAGES = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  output logic                      busy,
  input  wire  kms_pkg::in_word_t   item,
  output logic                      result_valid,
  output kms_pkg::out_word_t        result,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [3:0]                paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int IdxW = $clog2(MAX_NODES);
  localparam int CntW = IdxW + 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_P1_RD   = 11'b00000000010,
    S_P1_GO   = 11'b00000000100,
    S_P1_WAIT = 11'b00000001000,
    S_DIV_LD  = 11'b00000010000,
    S_DIV     = 11'b00000100000,
    S_P2_RD   = 11'b00001000000,
    S_P2_GO   = 11'b00010000000,
    S_P2_WAIT = 11'b00100000000,
    S_MUL     = 11'b01000000000,
    S_MPOST   = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    M_SC  = 3'd0,
    M_CS  = 3'd1,
    M_EPS = 3'd2,
    M_RAD = 3'd3,
    M_DT  = 3'd4
  } mop_t;

  state_t state;
  mop_t   mop;

  logic [6:0]         node_count;
  logic signed [23:0] coupling_gain;
  logic [15:0]        time_step;

  logic [31:0] phase_mem [MAX_NODES];
  logic [31:0] freq_mem [MAX_NODES];
  logic [31:0] phase_rd, freq_rd;
  logic        wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0] wr_data;

  logic [IdxW-1:0] j;
  logic [CntW-1:0] n_eff;
  logic            j_last;

  logic                 cor_start, cor_done;
  kms_pkg::cordic_res_t cor_res;

  logic signed [47:0] cos_accum, sin_accum;
  logic signed [35:0] c_mean, s_mean, cv, sv;

  logic            div_sel, div_neg;
  logic [5:0]      div_cnt;
  logic [47:0]     div_q, div_q_next;
  logic [CntW:0]   div_rem, div_r, div_rem_next;
  logic signed [47:0] div_res;

  logic [1:0]         mul_k;
  logic signed [47:0] mul_a, mul_b;
  logic signed [16:0] mul_dig;
  logic signed [64:0] mul_pp;
  logic signed [95:0] mul_ppx, mul_acc, t1, diff;
  logic signed [47:0] q, u, rate, omega;
  logic [31:0]        new_phase;

  logic cfg_we, load_acc;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign cfg_we = psel && penable && pwrite;
  assign load_acc = start && !busy && (item.opcode == kms_pkg::OpLoad);

  always_comb begin
    unique case (paddr[3:2])
      kms_pkg::RegNodeCount: prdata = {25'd0, node_count};
      kms_pkg::RegCouplingGain: prdata = {{8{coupling_gain[23]}}, coupling_gain};
      kms_pkg::RegTimeStep: prdata = {16'd0, time_step};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
      coupling_gain <= 24'sd65536;
      time_step <= 16'd655;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        kms_pkg::RegNodeCount: node_count <= pwdata[6:0];
        kms_pkg::RegCouplingGain: coupling_gain <= pwdata[23:0];
        kms_pkg::RegTimeStep: time_step <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_count == 7'd0) begin
      n_eff = CntW'(1);
    end else if (8'(node_count) > 8'(MAX_NODES)) begin
      n_eff = CntW'(MAX_NODES);
    end else begin
      n_eff = CntW'(node_count);
    end
  end
  assign j_last = ({1'b0, j} == CntW'(n_eff - 1'b1));

  always_comb begin
    wr_en = 1'b0;
    wr_addr = j;
    wr_data = new_phase;
    if (load_acc && (7'(item.node_index) < 7'(MAX_NODES))) begin
      wr_en = 1'b1;
      wr_addr = item.node_index[IdxW-1:0];
      wr_data = item.init_phase;
    end else if (state == S_MPOST && mop == M_DT) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      phase_mem[wr_addr] <= wr_data;
    end
    if (load_acc && (7'(item.node_index) < 7'(MAX_NODES))) begin
      freq_mem[item.node_index[IdxW-1:0]] <= item.natural_freq;
    end
    phase_rd <= phase_mem[j];
    freq_rd <= freq_mem[j];
  end

  assign cor_start = (state == S_P1_GO) || (state == S_P2_GO);

  kms_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cor_start),
    .angle(phase_rd),
    .done(cor_done),
    .res(cor_res)
  );

  always_comb begin
    div_r = {div_rem[CntW-1:0], div_q[47]};
    if (div_r >= {1'b0, n_eff}) begin
      div_rem_next = div_r - {1'b0, n_eff};
      div_q_next = {div_q[46:0], 1'b1};
    end else begin
      div_rem_next = div_r;
      div_q_next = {div_q[46:0], 1'b0};
    end
    div_res = div_neg ? -$signed(div_q_next) : $signed(div_q_next);
  end

  always_comb begin
    unique case (mop)
      M_SC: begin
        mul_a = 48'(s_mean);
        mul_b = 48'(cv);
      end
      M_CS: begin
        mul_a = 48'(c_mean);
        mul_b = 48'(sv);
      end
      M_EPS: begin
        mul_a = 48'(coupling_gain);
        mul_b = q;
      end
      M_RAD: begin
        mul_a = u;
        mul_b = kms_pkg::RadToBau;
      end
      M_DT: begin
        mul_a = rate;
        mul_b = $signed(48'(time_step));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    unique case (mul_k)
      2'd0: mul_dig = $signed({1'b0, mul_b[15:0]});
      2'd1: mul_dig = $signed({1'b0, mul_b[31:16]});
      2'd2: mul_dig = $signed({mul_b[47], mul_b[47:32]});
      default: mul_dig = '0;
    endcase
    mul_pp = 65'(mul_a * mul_dig);
    unique case (mul_k)
      2'd0: mul_ppx = 96'(mul_pp);
      2'd1: mul_ppx = 96'(mul_pp) <<< 16;
      2'd2: mul_ppx = 96'(mul_pp) <<< 32;
      default: mul_ppx = '0;
    endcase
    diff = t1 - mul_acc;
    omega = 48'($signed(freq_rd));
    new_phase = phase_rd + mul_acc[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      cos_accum <= '0;
      sin_accum <= '0;
      j <= '0;
      mop <= M_SC;
      mul_k <= '0;
      div_sel <= 1'b0;
      div_cnt <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && item.opcode == kms_pkg::OpStep) begin
            cos_accum <= '0;
            sin_accum <= '0;
            j <= '0;
            state <= S_P1_RD;
          end
        end
        S_P1_RD: state <= S_P1_GO;
        S_P1_GO: state <= S_P1_WAIT;
        S_P1_WAIT: begin
          if (cor_done) begin
            cos_accum <= cos_accum + 48'(cor_res.cos_v);
            sin_accum <= sin_accum + 48'(cor_res.sin_v);
            if (j_last) begin
              div_sel <= 1'b0;
              state <= S_DIV_LD;
            end else begin
              j <= j + 1'b1;
              state <= S_P1_RD;
            end
          end
        end
        S_DIV_LD: begin
          div_neg <= div_sel ? sin_accum[47] : cos_accum[47];
          div_q <= div_sel ? 48'(sin_accum[47] ? -sin_accum : sin_accum)
                           : 48'(cos_accum[47] ? -cos_accum : cos_accum);
          div_rem <= '0;
          div_cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          div_q <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd47) begin
            if (div_sel) begin
              s_mean <= 36'(div_res);
              j <= '0;
              state <= S_P2_RD;
            end else begin
              c_mean <= 36'(div_res);
              div_sel <= 1'b1;
              state <= S_DIV_LD;
            end
          end
        end
        S_P2_RD: state <= S_P2_GO;
        S_P2_GO: state <= S_P2_WAIT;
        S_P2_WAIT: begin
          if (cor_done) begin
            cv <= cor_res.cos_v;
            sv <= cor_res.sin_v;
            mop <= M_SC;
            mul_k <= '0;
            mul_acc <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mul_acc <= mul_acc + mul_ppx;
          if (mul_k == 2'd2) begin
            state <= S_MPOST;
          end else begin
            mul_k <= mul_k + 1'b1;
          end
        end
        S_MPOST: begin
          mul_k <= '0;
          mul_acc <= '0;
          state <= S_MUL;
          unique case (mop)
            M_SC: begin
              t1 <= mul_acc;
              mop <= M_CS;
            end
            M_CS: begin
              q <= 48'(diff >>> 30);
              mop <= M_EPS;
            end
            M_EPS: begin
              u <= 48'(mul_acc >>> 24);
              mop <= M_RAD;
            end
            M_RAD: begin
              rate <= omega + 48'(mul_acc >>> 22);
              mop <= M_DT;
            end
            M_DT: begin
              result_valid <= 1'b1;
              result.out_node <= 6'(j);
              result.phase <= new_phase;
              result.last <= j_last;
              mop <= M_SC;
              if (j_last) begin
                state <= S_IDLE;
              end else begin
                j <= j + 1'b1;
                state <= S_P2_RD;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_from_post: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_MPOST))
    else $error("result word without a finished update");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("engine still busy after the last word");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, j} < n_eff))
    else $error("node index beyond node count");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> !busy)
    else $error("load word started a step");

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for the Kuramoto mean-field step unit with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none

class phase_scoreboard;
  logic [31:0] phase_mem[64];
  logic [31:0] freq_mem[64];
  logic [6:0] node_count;
  logic signed [23:0] coupling_gain;
  logic [15:0] time_step;
  kms_pkg::out_word_t expected_q[$];
  int errors;

  function new();
    for (int k = 0; k < 64; k++) begin
      phase_mem[k] = '0;
      freq_mem[k] = '0;
    end
    node_count = 7'd64;
    coupling_gain = 24'sd65536;
    time_step = 16'd655;
    errors = 0;
  endfunction

  function automatic void rotate(input logic [31:0] a, output longint co,
                                 output longint si);
    logic flip;
    longint z, x, y, xs, ys;
    flip = ((a + 32'h40000000) & 32'h80000000) != 0;
    if (flip) begin
      a = a ^ 32'h80000000;
    end
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(kms_pkg::atan_angle(i[4:0]));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(kms_pkg::atan_angle(i[4:0]));
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    co = x;
    si = y;
  endfunction

  function automatic void note_input(input kms_pkg::in_word_t w);
    longint cv[64], sv[64];
    longint csum, ssum, c, s, q, u, v, rate, delta, eps;
    int n;
    kms_pkg::out_word_t r;
    if (w.opcode == kms_pkg::OpLoad) begin
      freq_mem[w.node_index] = w.natural_freq;
      phase_mem[w.node_index] = w.init_phase;
      return;
    end
    n = node_count;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    csum = 0;
    ssum = 0;
    for (int j = 0; j < n; j++) begin
      rotate(phase_mem[j], cv[j], sv[j]);
      csum += cv[j];
      ssum += sv[j];
    end
    c = csum / n;
    s = ssum / n;
    eps = longint'(coupling_gain);
    for (int j = 0; j < n; j++) begin
      q = (s * cv[j] - c * sv[j]) >>> 30;
      u = (eps * q) >>> 24;
      v = (u * 683565276) >>> 22;
      rate = longint'($signed(freq_mem[j])) + v;
      delta = (rate * longint'(time_step)) >>> 16;
      phase_mem[j] = phase_mem[j] + delta[31:0];
      r.out_node = j[5:0];
      r.phase = phase_mem[j];
      r.last = (j == n - 1);
      expected_q.push_back(r);
    end
  endfunction

  function automatic void check_result(input kms_pkg::out_word_t got);
    kms_pkg::out_word_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.out_node !== e.out_node) begin
      $display("%0t: out_node expected %0d actual %0d", $time, e.out_node, got.out_node);
      errors++;
    end
    if (got.phase !== e.phase) begin
      $display("%0t: phase expected %h actual %h", $time, e.phase, got.phase);
      errors++;
    end
    if (got.last !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  kms_pkg::in_word_t item = '0;
  logic result_valid;
  kms_pkg::out_word_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int idle_cycles = 0;
  logic [63:0] loaded = '0;
  logic [6:0] active_nodes = 7'd64;
  phase_scoreboard board = new();

  kuramoto_mean_field_step_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      board.check_result(result);
    end
    if (!rst && (result_valid || (start && !busy))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      kms_pkg::RegNodeCount: begin
        board.node_count = value[6:0];
        active_nodes = (value[6:0] == 0) ? 7'd1 : (value[6:0] > 64 ? 7'd64 : value[6:0]);
      end
      kms_pkg::RegCouplingGain: board.coupling_gain = value[23:0];
      kms_pkg::RegTimeStep: board.time_step = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input kms_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    board.note_input(w);
    if (w.opcode == kms_pkg::OpLoad) loaded[w.node_index] = 1'b1;
  endtask

  task automatic load_node(input logic [5:0] idx, input logic [31:0] f, input logic [31:0] p);
    kms_pkg::in_word_t w;
    w.opcode = kms_pkg::OpLoad;
    w.node_index = idx;
    w.natural_freq = f;
    w.init_phase = p;
    send_word(w);
  endtask

  function automatic bit check_loaded();
    for (int k = 0; k < active_nodes; k++) if (!loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic step_nodes();
    kms_pkg::in_word_t w;
    w.opcode = kms_pkg::OpStep;
    w.node_index = 6'($urandom());
    w.natural_freq = $urandom();
    w.init_phase = $urandom();
    if (check_loaded()) send_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(kms_pkg::RegNodeCount, 32'd4);
    load_node(6'd0, 32'h7FFFFFFF, 32'h00000000);
    load_node(6'd1, 32'h80000000, 32'hFFFFFFFF);
    load_node(6'd2, 32'h00000000, 32'h40000000);
    load_node(6'd3, 32'hFFFFFFFF, 32'hC0000000);
    step_nodes();
    drain();
    write_reg(kms_pkg::RegNodeCount, 32'd0);
    write_reg(kms_pkg::RegCouplingGain, 32'h7FFFFF);
    write_reg(kms_pkg::RegTimeStep, 32'hFFFF);
    step_nodes();
    drain();
    write_reg(kms_pkg::RegCouplingGain, 32'h800000);
    write_reg(kms_pkg::RegTimeStep, 32'd0);
    write_reg(kms_pkg::RegNodeCount, 32'd2);
    step_nodes();
    drain();
    write_reg(kms_pkg::RegTimeStep, 32'd655);
    for (int k = 0; k < 64; k++) begin
      load_node(k[5:0], $urandom(), $urandom());
    end
    write_reg(kms_pkg::RegNodeCount, 32'd64);
    step_nodes();
    drain();
    write_reg(kms_pkg::RegNodeCount, 32'd127);
    step_nodes();
    drain();
    for (int phase_set = 0; phase_set < 6; phase_set++) begin
      write_reg(kms_pkg::RegNodeCount, $urandom_range(1, 12));
      write_reg(kms_pkg::RegCouplingGain, $urandom());
      write_reg(kms_pkg::RegTimeStep, $urandom());
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          step_nodes();
        end else begin
          load_node(6'($urandom_range(0, 15)), $urandom(), $urandom());
        end
      end
      drain();
    end
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
